@@ design/jsu_pkg.sv @@
`timescale 1ns / 1ps

package jsu_pkg;

  // width of the running decoded byte count
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [15:0] LEN_REPORT_MAX = 16'hFFFF;

  // results one input byte can cause
  localparam int MAX_RESULTS = 3;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_BAD_ESC = 3'd2,
    ST_BAD_HEX = 3'd3,
    ST_UNTERM  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    status_t     status;
    logic        last_of_run;
    logic [15:0] string_len;
  } out_item_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]                  n;
    out_item_t [MAX_RESULTS-1:0] items;
  } group_t;

  // saturating add of up to three bytes
  function automatic logic [LENGTH_BITS-1:0] count_add(logic [LENGTH_BITS-1:0] cnt,
                                                       logic [1:0] add);
    logic [LENGTH_BITS+1:0] sum;
    sum = {2'b00, cnt} + (LENGTH_BITS+2)'(add);
    if (sum > {2'b00, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return sum[LENGTH_BITS-1:0];
  endfunction

  // reported length saturates at 16 bits
  function automatic logic [15:0] len_report(logic [LENGTH_BITS-1:0] cnt);
    logic [LENGTH_BITS+15:0] wide;
    wide = (LENGTH_BITS+16)'(cnt);
    if (wide > (LENGTH_BITS+16)'(LEN_REPORT_MAX)) begin
      return LEN_REPORT_MAX;
    end
    return wide[15:0];
  endfunction

endpackage

@@ design/jsu_in_if.sv @@
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ design/jsu_out_if.sv @@
`timescale 1ns / 1ps

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic        last_of_run;
  logic [15:0] string_len;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  output string_len, input ready);
  modport sink (input valid, input out_byte, input status, input last_of_run,
                input string_len, output ready);
endinterface

@@ design/jsu_in_stage.sv @@
`timescale 1ns / 1ps

module jsu_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  jsu_pkg::in_item_t req_item,
  input  logic              take,
  output logic              hold_valid,
  output jsu_pkg::in_item_t hold_item
);
  import jsu_pkg::*;

  assign req_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      hold_item <= req_item;
    end
  end
endmodule

@@ design/jsu_decode.sv @@
`timescale 1ns / 1ps

module jsu_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  jsu_pkg::in_item_t item,
  output jsu_pkg::group_t   grp
);
  import jsu_pkg::*;

  typedef enum logic [5:0] {
    PH_TEXT = 6'b000001,
    PH_ESC  = 6'b000010,
    PH_HEX1 = 6'b000100,
    PH_HEX2 = 6'b001000,
    PH_HEX3 = 6'b010000,
    PH_HEX4 = 6'b100000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [15:0]            code_point, code_point_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;

  logic [7:0]  c;
  logic [1:0]  add;
  logic        clear;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [7:0]  esc_byte;
  logic        esc_ok;
  logic [15:0] cp;

  assign c = item.in_byte;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    priority if (c >= "0" && c <= "9") begin
      digit = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      digit = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      digit = 4'(c - "A" + 8'd10);
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    unique case (c)
      8'h22:   esc_byte = 8'h22;
      8'h5C:   esc_byte = 8'h5C;
      8'h2F:   esc_byte = 8'h2F;
      "b":     esc_byte = 8'h08;
      "f":     esc_byte = 8'h0C;
      "n":     esc_byte = 8'h0A;
      "r":     esc_byte = 8'h0D;
      "t":     esc_byte = 8'h09;
      default: begin
        esc_byte = 8'h00;
        esc_ok   = 1'b0;
      end
    endcase
  end

  assign cp = {code_point[11:0], digit};

  always_comb begin
    phase_next      = phase;
    code_point_next = code_point;
    add             = 2'd0;
    clear           = 1'b0;
    grp             = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      grp.items[i].status = ST_BYTE;
    end

    if (item.end_of_input || c == 8'h00) begin
      grp.n               = 2'd1;
      grp.items[0].status = ST_UNTERM;
      clear               = 1'b1;
    end else begin
      unique case (phase)
        PH_ESC: begin
          if (c == "u") begin
            phase_next      = PH_HEX1;
            code_point_next = 16'h0000;
          end else if (esc_ok) begin
            grp.n                 = 2'd1;
            grp.items[0].out_byte = esc_byte;
            add                   = 2'd1;
            phase_next            = PH_TEXT;
          end else begin
            grp.n               = 2'd1;
            grp.items[0].status = ST_BAD_ESC;
            clear               = 1'b1;
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (!digit_ok) begin
            grp.n               = 2'd1;
            grp.items[0].status = ST_BAD_HEX;
            clear               = 1'b1;
          end else if (phase == PH_HEX4) begin
            phase_next      = PH_TEXT;
            code_point_next = 16'h0000;
            priority if (cp <= 16'h007F) begin
              grp.n                 = 2'd1;
              grp.items[0].out_byte = cp[7:0];
            end else if (cp <= 16'h07FF) begin
              grp.n                 = 2'd2;
              grp.items[0].out_byte = 8'hC0 | {3'b000, cp[10:6]};
              grp.items[1].out_byte = 8'h80 | {2'b00, cp[5:0]};
            end else begin
              grp.n                 = 2'd3;
              grp.items[0].out_byte = 8'hE0 | {4'h0, cp[15:12]};
              grp.items[1].out_byte = 8'h80 | {2'b00, cp[11:6]};
              grp.items[2].out_byte = 8'h80 | {2'b00, cp[5:0]};
            end
            add = grp.n;
          end else begin
            code_point_next = cp;
            phase_next      = phase_t'({phase[4:0], 1'b0});
          end
        end
        default: begin
          phase_next = PH_TEXT;
          if (c == 8'h5C) begin
            phase_next = PH_ESC;
          end else if (c == 8'h22) begin
            grp.n                   = 2'd1;
            grp.items[0].status     = ST_DONE;
            grp.items[0].string_len = len_report(byte_count);
            clear                   = 1'b1;
          end else begin
            grp.n                 = 2'd1;
            grp.items[0].out_byte = c;
            add                   = 2'd1;
          end
        end
      endcase
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (grp.n == 2'(i + 1)) begin
        grp.items[i].last_of_run = 1'b1;
      end
    end

    byte_count_next = count_add(byte_count, add);
    if (clear) begin
      phase_next      = PH_TEXT;
      code_point_next = 16'h0000;
      byte_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TEXT;
      code_point <= 16'h0000;
      byte_count <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      code_point <= code_point_next;
      byte_count <= byte_count_next;
    end
  end
endmodule

@@ design/jsu_out_buf.sv @@
`timescale 1ns / 1ps

module jsu_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  jsu_pkg::group_t    grp,
  output logic               can_load,
  output logic               res_valid,
  input  logic               res_ready,
  output jsu_pkg::out_item_t res_item
);
  import jsu_pkg::*;

  out_item_t [MAX_RESULTS-1:0] entries;
  logic [1:0]                  rem;
  logic                        take;

  assign res_valid = (rem != 2'd0);
  assign res_item  = entries[0];
  assign take      = res_valid && res_ready;
  assign can_load  = (rem == 2'd0) || (rem == 2'd1 && res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= grp.n;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= grp.items;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end
endmodule

@@ design/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps

// json string body unescaper with utf-8 output. feed the bytes that follow
// the opening quote, one request per byte; plain bytes come out unchanged,
// the two-character escapes become one byte and \uXXXX becomes one to three
// utf-8 bytes (surrogate halves are encoded separately, never paired). a
// closing quote yields one "done" result carrying the decoded length, which
// saturates at 65535; a bad escape letter, a bad hex digit, a zero byte or
// end_of_input yield one error result, bytes already sent stand and the
// block is back in plain text. last_of_run marks the final result of each
// input byte; a backslash and the \u hex digits before the last give none.
// throughput is one input byte per cycle while results are taken; a byte
// producing two or three utf-8 bytes holds the input until the single-entry
// result group, draining one result per cycle while results are taken, can
// load; bytes pass the input register, then the result group register.
module json_string_unescape_utf8 (
  input logic      clk,
  input logic      rst,
  jsu_in_if.sink   in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  in_item_t  req_item;
  in_item_t  hold_item;
  logic      hold_valid;
  logic      can_load;
  logic      fire;
  group_t    grp;
  out_item_t res_item;

  assign req_item.in_byte      = in_ch.in_byte;
  assign req_item.end_of_input = in_ch.end_of_input;

  // input register: frees itself whenever its byte is decoded
  jsu_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req_item  (req_item),
    .take      (fire),
    .hold_valid(hold_valid),
    .hold_item (hold_item)
  );

  // decode happens when the result group is empty or emptying this cycle
  assign fire = hold_valid && can_load;

  // phase, hex accumulator and length counter, plus the result group logic
  jsu_decode u_dec (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .item(hold_item),
    .grp (grp)
  );

  // result group register, shifts out one result per accepted output request
  jsu_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .grp      (grp),
    .can_load (can_load),
    .res_valid(out_ch.valid),
    .res_ready(out_ch.ready),
    .res_item (res_item)
  );

  assign out_ch.out_byte    = res_item.out_byte;
  assign out_ch.status      = res_item.status;
  assign out_ch.last_of_run = res_item.last_of_run;
  assign out_ch.string_len  = res_item.string_len;

`ifndef ASSERT_OFF
  // any non-byte result is the only one for its input byte
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_BYTE |-> out_ch.last_of_run)
    else $error("non-byte result not marked last");

  // only a done result carries a length
  a_len_only_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_DONE |-> out_ch.string_len == 16'h0000)
    else $error("length on a result other than done");

  // a decoded byte with results presents one on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    fire && grp.n != 2'd0 |=> out_ch.valid)
    else $error("result group loaded but not shown");
`endif
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  // timeout, far above the slowest legal run of stalled traffic
  localparam int CYCLE_LIMIT = 20000;
  // random requests per idle setting, about 430 in all with the directed bytes
  localparam int RANDOM_PER_PHASE = 124;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // scanner phases of the predictor
  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_HEX3 = 3'd4,
    PH_HEX4 = 3'd5
  } scan_phase_t;

  // predicts the decoded byte stream and checks the block's results against it
  class unescape_scoreboard;
    scan_phase_t             phase;
    logic [15:0]             code_point;
    logic [LENGTH_BITS-1:0]  count;
    out_item_t               pending[$];
    int                      mismatches;
    int                      checked;
    int                      strings_done;
    int                      error_reports;

    function new();
      clear_string();
      mismatches = 0;
      checked = 0;
      strings_done = 0;
      error_reports = 0;
    endfunction

    function void clear_string();
      phase = PH_TEXT;
      code_point = 16'h0;
      count = '0;
    endfunction

    function out_item_t make_result(logic [7:0] b, status_t st, logic [15:0] len);
      out_item_t r;
      r.out_byte = b;
      r.status = st;
      r.last_of_run = 1'b0;
      r.string_len = len;
      return r;
    endfunction

    // decoded byte, counted toward the string length (count sticks at its top)
    function out_item_t count_byte(logic [7:0] b);
      if (count != COUNT_MAX) begin
        count = count + 1'b1;
      end
      return make_result(b, ST_BYTE, 16'h0);
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    // one accepted request: work out every result it causes
    function void note_request(logic [7:0] c, logic eoi);
      out_item_t grp[3];
      int        n;
      int        d;
      logic [7:0] esc;
      n = 0;
      if (eoi || c == 8'h00) begin
        // end of input or zero byte, in any phase
        grp[0] = make_result(8'h00, ST_UNTERM, 16'h0);
        n = 1;
        clear_string();
      end else if (phase == PH_TEXT) begin
        if (c == CH_BSLASH) begin
          phase = PH_ESC;
        end else if (c == CH_QUOTE) begin
          grp[0] = make_result(8'h00, ST_DONE,
                               (32'(count) > 32'hFFFF) ? 16'hFFFF : 16'(count));
          n = 1;
          clear_string();
        end else begin
          grp[0] = count_byte(c);
          n = 1;
        end
      end else if (phase == PH_ESC) begin
        phase = PH_TEXT;
        esc = 8'h00;
        case (c)
          CH_QUOTE:  esc = 8'h22;
          CH_BSLASH: esc = 8'h5C;
          "/":       esc = 8'h2F;
          "b":       esc = 8'h08;
          "f":       esc = 8'h0C;
          "n":       esc = 8'h0A;
          "r":       esc = 8'h0D;
          "t":       esc = 8'h09;
          default:   esc = 8'h00;
        endcase
        if (c == CH_U) begin
          phase = PH_HEX1;
          code_point = 16'h0;
        end else if (esc != 8'h00) begin
          grp[0] = count_byte(esc);
          n = 1;
        end else begin
          grp[0] = make_result(8'h00, ST_BAD_ESC, 16'h0);
          n = 1;
          clear_string();
        end
      end else begin
        d = hex_value(c);
        if (d < 0) begin
          grp[0] = make_result(8'h00, ST_BAD_HEX, 16'h0);
          n = 1;
          clear_string();
        end else begin
          code_point = {code_point[11:0], 4'(d)};
          if (phase == PH_HEX4) begin
            // utf-8: one, two or three bytes by code point range
            if (code_point <= 16'h007F) begin
              grp[0] = count_byte(code_point[7:0]);
              n = 1;
            end else if (code_point <= 16'h07FF) begin
              grp[0] = count_byte(8'hC0 | 8'(code_point >> 6));
              grp[1] = count_byte(8'h80 | (code_point[7:0] & 8'h3F));
              n = 2;
            end else begin
              grp[0] = count_byte(8'hE0 | 8'(code_point >> 12));
              grp[1] = count_byte(8'h80 | (8'(code_point >> 6) & 8'h3F));
              grp[2] = count_byte(8'h80 | (code_point[7:0] & 8'h3F));
              n = 3;
            end
            phase = PH_TEXT;
            code_point = 16'h0;
          end else begin
            phase = scan_phase_t'(phase + 3'd1);
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        grp[i].last_of_run = (i == n - 1);
        pending.push_back(grp[i]);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0d last %0b length %0d",
               got.out_byte, got.status, got.last_of_run, got.string_len);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (exp.status == ST_DONE) strings_done++;
      if (exp.status > ST_DONE) error_reports++;
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.last_of_run !== exp.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", exp.last_of_run, got.last_of_run);
        mismatches++;
      end
      if (got.string_len !== exp.string_len) begin
        $error("string_len: expected %0d, got %0d",
               exp.string_len, got.string_len);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_utf8 DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unescape_scoreboard sb;

  int tx_idle_pct = 21;
  int rx_idle_pct = 58;
  int sent = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver: stalls at random, per cycle, at the current rate
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // monitor: predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    out_item_t got;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte = out_ch.out_byte;
        got.status = status_t'(out_ch.status);
        got.last_of_run = out_ch.last_of_run;
        got.string_len = out_ch.string_len;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.in_byte, in_ch.end_of_input);
      end
    end
  end

  // timeout watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // one request; valid stays up into the next request unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      // junk on the payload while valid is low
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      in_ch.end_of_input <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    // either letter case is legal
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // \u escape with digits in random case
  task automatic send_code_point(input logic [15:0] cp);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b0);
    send_byte(hex_char(cp[15:12]), 1'b0);
    send_byte(hex_char(cp[11:8]), 1'b0);
    send_byte(hex_char(cp[7:4]), 1'b0);
    send_byte(hex_char(cp[3:0]), 1'b0);
  endtask

  // mostly well-formed string pieces, with some broken escapes and early ends
  task automatic send_random_token();
    logic [7:0] letters[8] = '{8'h22, 8'h5C, "/", "b", "f", "n", "r", "t"};
    logic [7:0] b;
    int         r;
    int         k;
    r = $urandom_range(99);
    if (r < 45) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_BSLASH || b == CH_QUOTE);
      send_byte(b, 1'b0);
    end else if (r < 57) begin
      send_byte(CH_BSLASH, 1'b0);
      send_byte(letters[$urandom_range(7)], 1'b0);
    end else if (r < 72) begin
      case ($urandom_range(2))
        0: send_code_point(16'($urandom_range(16'h0000, 16'h007F)));
        1: send_code_point(16'($urandom_range(16'h0080, 16'h07FF)));
        default: send_code_point(16'($urandom_range(16'h0800, 16'hFFFF)));
      endcase
    end else if (r < 80) begin
      send_byte(CH_QUOTE, 1'b0);
    end else if (r < 85) begin
      // escape letter drawn at random, usually not a legal one
      send_byte(CH_BSLASH, 1'b0);
      send_byte(8'($urandom_range(1, 255)), 1'b0);
    end else if (r < 90) begin
      // \u run broken after a few digits
      send_byte(CH_BSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      k = $urandom_range(3);
      for (int i = 0; i < k; i++) send_byte(hex_char(4'($urandom)), 1'b0);
      send_byte(8'($urandom_range(1, 255)), 1'b0);
    end else if (r < 95) begin
      send_byte(8'($urandom), 1'b1);
    end else begin
      send_byte(8'h00, 1'b0);
    end
  endtask

  task automatic random_phase();
    int start;
    start = sent;
    while (sent - start < RANDOM_PER_PHASE) send_random_token();
  endtask

  initial begin
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, every two-character escape, utf-8 widths,
    // surrogate half, mixed-case hex, closing quote
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
    send_text("\\u0000\\u07fF\\ud83D\\uFfFf\"");
    // bad escape letter, bad hex digit
    send_text("\\x");
    send_text("\\u1g");
    // end of input in text, after a backslash and inside a hex run
    send_text("a");
    send_byte(8'hA5, 1'b1);
    send_text("\\");
    send_byte(8'h5A, 1'b1);
    send_text("\\uA");
    send_byte(8'h00, 1'b1);
    // zero byte, then an empty string
    send_byte(8'h00, 1'b0);
    send_byte(CH_QUOTE, 1'b0);

    random_phase();
    tx_idle_pct = 58;
    rx_idle_pct = 21;
    random_phase();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase();

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // a few more cycles to catch stray results
    repeat (12) @(posedge clk);

    $display("run covered %0d input bytes: directed escapes and errors, then three idle settings",
             sent);
    $display("%0d results checked, %0d strings closed, %0d error reports",
             sb.checked, sb.strings_done, sb.error_reports);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
